/* hw/rtl/life_grid_generation_engine_defines.svh */
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared property wrappers, clocked on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication
`define LGGE_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LGGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lgge_pkg.sv */
// ----------------------------------------------------------------------------
// Life grid engine package
// Field widths, operation codes, rule constants and the column tap type.
// ----------------------------------------------------------------------------
package lgge_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int CFG_W   = 7;
    localparam int KIND_W  = 2;
    localparam int COORD_W = 6;
    localparam int NBR_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

    localparam logic [NBR_W-1:0] BIRTH_N   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_N = 4'd2;

    // One column of the three-row window, as seen by the neighboring cells
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } lgge_col_t;

endpackage

/* hw/rtl/lgge_if.sv */
// ----------------------------------------------------------------------------
// Life grid engine channels
// Valid/ready command and response channels.
// ----------------------------------------------------------------------------
interface lgge_cmd_if import lgge_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               cell_value;

    modport source (output valid, output kind, output col, output row,
                    output cell_value, input ready);
    modport sink   (input valid, input kind, input col, input row,
                    input cell_value, output ready);
endinterface

interface lgge_res_if import lgge_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] done_kind;
    logic              read_state;
    logic              out_of_range;

    modport source (output valid, output done_kind, output read_state,
                    output out_of_range, input ready);
    modport sink   (input valid, input done_kind, input read_state,
                    input out_of_range, output ready);
endinterface

/* hw/rtl/lgge_row_mem.sv */
// ----------------------------------------------------------------------------
// Life grid row memory
// One row per entry, bit-masked write port, registered read port.
// ----------------------------------------------------------------------------
module lgge_row_mem import lgge_pkg::*; #(
    parameter int  ROWS = DEF_MAX_ROWS,
    parameter int  COLS = DEF_MAX_COLS,
    localparam int AW   = $clog2(ROWS)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [COLS-1:0] wdata,
    input  logic [COLS-1:0] wmask,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output logic [COLS-1:0] rdata
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < COLS; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lgge_cell.sv */
// ----------------------------------------------------------------------------
// Life grid column cell
// Holds the upper and middle bits of one column of the sliding window and
// applies the B3/S23 rule to the middle bit.
// ----------------------------------------------------------------------------
module lgge_cell import lgge_pkg::*; (
    input  logic      clk,
    input  logic      shift,
    input  logic      col_en,
    input  logic      dn,
    input  lgge_col_t nbr_w,
    input  lgge_col_t nbr_e,
    output lgge_col_t tap,
    output logic      nxt
);

    logic             up_reg;
    logic             up_next;
    logic             mid_reg;
    logic             mid_next;
    logic [NBR_W-1:0] count;

    always_comb
    begin
        up_next  = shift ? mid_reg : up_reg;
        mid_next = shift ? dn : mid_reg;
    end

    // Columns outside the grid look dead to their neighbors
    assign tap.up  = up_reg & col_en;
    assign tap.mid = mid_reg & col_en;
    assign tap.dn  = dn & col_en;

    assign count = NBR_W'(nbr_w.up) + NBR_W'(nbr_w.mid) + NBR_W'(nbr_w.dn)
                 + NBR_W'(nbr_e.up) + NBR_W'(nbr_e.mid) + NBR_W'(nbr_e.dn)
                 + NBR_W'(up_reg) + NBR_W'(dn);

    // Keep the stored bit of a column outside the grid
    assign nxt = col_en ? ((count == BIRTH_N) || (mid_reg && (count == SURVIVE_N)))
                        : mid_reg;

    always_ff @(posedge clk)
    begin
        up_reg  <= up_next;
        mid_reg <= mid_next;
    end

endmodule

/* hw/rtl/life_grid_generation_engine.sv */
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded Game of Life grid (B3/S23, no wraparound) with cell write, cell
// read and one-generation step commands, sized by two APB registers.
// ----------------------------------------------------------------------------
// After reset the engine clears every row of its row memory and takes no
// command until that is done. A cell write posts its response straight from
// the accepted command; a cell read first waits for the registered row memory. A
// generation step sweeps the grid one row per cycle through a chain of
// MAX_COLS column cells holding a three-row window, writing each new row
// once the window has filled, and the response is posted together with the
// last row. One command is in flight at a time; a response waits in an
// output register, and the next command is taken in the cycle that response
// beat is consumed.
// Register 0 (byte 0) is grid_width, register 1 (byte 4) grid_height.
`include "life_grid_generation_engine_defines.svh"

module life_grid_generation_engine import lgge_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    lgge_cmd_if.sink           cmd,
    lgge_res_if.source         res
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CNT_W  = ($clog2(MAX_ROWS + 2) > CFG_W) ? $clog2(MAX_ROWS + 2) : CFG_W;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_GEN  = 2'd3;

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic             cfg_wr;
    logic [CFG_W-1:0] eff_w;
    logic [CNT_W-1:0] eff_h;
    logic [CNT_W-1:0] h_ext;

    // Control
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] wr_row;
    logic             rvld_reg;
    logic             rvld_next;
    logic             cmd_fire;
    logic             in_grid;
    logic [CFG_W-1:0] col_ext;
    logic [CNT_W-1:0] row_ext;
    logic [COL_W-1:0] col_idx;
    logic [ROW_W-1:0] row_idx;
    logic [COL_W-1:0] rd_col_reg;
    logic [COL_W-1:0] rd_col_next;
    logic             rd_oor_reg;
    logic             rd_oor_next;

    // Memory port
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic [MAX_COLS-1:0] mem_wmask;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_raddr;
    logic [MAX_COLS-1:0] mem_rdata;

    // Cell chain
    logic                shift;
    logic [MAX_COLS-1:0] next_row;
    lgge_col_t           taps [MAX_COLS];

    // Response register
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              out_load;
    logic [KIND_W-1:0] load_kind;
    logic              load_state;
    logic              load_oor;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_state_reg;
    logic              out_oor_reg;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp the grid size into 1..built maximum
    assign h_ext = CNT_W'(height_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(MAX_COLS))
        begin
            eff_w = CFG_W'(MAX_COLS);
        end
        else
        begin
            eff_w = width_reg;
        end

        if (h_ext == '0)
        begin
            eff_h = CNT_W'(1);
        end
        else if (h_ext > CNT_W'(MAX_ROWS))
        begin
            eff_h = CNT_W'(MAX_ROWS);
        end
        else
        begin
            eff_h = h_ext;
        end
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_vld_reg || res.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign col_ext   = CFG_W'(cmd.col);
    assign row_ext   = CNT_W'(cmd.row);
    assign in_grid   = (col_ext < eff_w) && (row_ext < eff_h);
    assign col_idx   = col_ext[COL_W-1:0];
    assign row_idx   = row_ext[ROW_W-1:0];
    assign wr_row    = cnt_reg - CNT_W'(2);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_col_next = rd_col_reg;
        rd_oor_next = rd_oor_reg;
        mem_we      = 1'b0;
        mem_waddr   = cnt_reg[ROW_W-1:0];
        mem_wdata   = '0;
        mem_wmask   = '1;
        mem_re      = 1'b0;
        mem_raddr   = cnt_reg[ROW_W-1:0];
        shift       = 1'b0;
        out_load    = 1'b0;
        load_kind   = KIND_WRITE;
        load_state  = 1'b0;
        load_oor    = 1'b0;

        case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CNT_W'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.kind)
                        KIND_WRITE:
                        begin
                            mem_we    = in_grid;
                            mem_waddr = row_idx;
                            mem_wdata = {MAX_COLS{cmd.cell_value}};
                            mem_wmask = {{(MAX_COLS - 1){1'b0}}, 1'b1} << col_idx;
                            out_load  = 1'b1;
                            load_kind = KIND_WRITE;
                            load_oor  = !in_grid;
                        end
                        KIND_READ:
                        begin
                            mem_re      = in_grid;
                            mem_raddr   = row_idx;
                            rd_col_next = col_idx;
                            rd_oor_next = !in_grid;
                            state_next  = ST_READ;
                        end
                        KIND_STEP:
                        begin
                            cnt_next   = '0;
                            state_next = ST_GEN;
                        end
                        default:
                        begin
                            // drop the reserved code
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                out_load   = 1'b1;
                load_kind  = KIND_READ;
                load_state = !rd_oor_reg && mem_rdata[rd_col_reg];
                load_oor   = rd_oor_reg;
                state_next = ST_IDLE;
            end

            ST_GEN:
            begin
                // fetch row cnt, window center holds row cnt-2
                shift  = 1'b1;
                mem_re = cnt_reg < eff_h;
                if (cnt_reg >= CNT_W'(2))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_row[ROW_W-1:0];
                    mem_wdata = next_row;
                end
                if (cnt_reg == eff_h + CNT_W'(1))
                begin
                    out_load   = 1'b1;
                    load_kind  = KIND_STEP;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rvld_next    = shift && mem_re;
    assign out_vld_next = out_load || (out_vld_reg && !res.ready);

    // ------------------------------------------------------------------
    // Row memory and cell chain
    // ------------------------------------------------------------------
    lgge_row_mem #(
        .ROWS (MAX_ROWS),
        .COLS (MAX_COLS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .wmask (mem_wmask),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_cell
        lgge_col_t west;
        lgge_col_t east;
        logic      col_en;
        logic      dn;

        assign col_en = CFG_W'(c) < eff_w;
        // rows past the grid read as dead
        assign dn     = rvld_reg && mem_rdata[c];

        if (c == 0)
        begin : g_west_edge
            assign west = '0;
        end
        else
        begin : g_west
            assign west = taps[c - 1];
        end

        if (c == MAX_COLS - 1)
        begin : g_east_edge
            assign east = '0;
        end
        else
        begin : g_east
            assign east = taps[c + 1];
        end

        lgge_cell u_cell (
            .clk    (clk),
            .shift  (shift),
            .col_en (col_en),
            .dn     (dn),
            .nbr_w  (west),
            .nbr_e  (east),
            .tap    (taps[c]),
            .nxt    (next_row[c])
        );
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= GRID_DIM_RESET;
            height_reg  <= GRID_DIM_RESET;
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            rvld_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rvld_reg    <= rvld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_col_reg <= rd_col_next;
        rd_oor_reg <= rd_oor_next;
        if (out_load)
        begin
            out_kind_reg  <= load_kind;
            out_state_reg <= load_state;
            out_oor_reg   <= load_oor;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.done_kind    = out_kind_reg;
    assign res.read_state   = out_state_reg;
    assign res.out_of_range = out_oor_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LGGE_ASSERT_HOLDS(a_oor_reads_dead, out_vld_reg && out_oor_reg, !out_state_reg,
                       "out-of-range beat carries a live cell")
    `LGGE_ASSERT_HOLDS(a_no_rsvd_beat, out_vld_reg, out_kind_reg != KIND_RSVD,
                       "response beat for reserved kind")
    `LGGE_ASSERT_HOLDS(a_gen_cnt_bound, state_reg == ST_GEN, cnt_reg <= eff_h + CNT_W'(1),
                       "sweep counter ran past the grid")
    `LGGE_ASSERT_HOLDS(a_gen_wr_bound, (state_reg == ST_GEN) && mem_we, wr_row < eff_h,
                       "sweep wrote a row outside the grid")
    `LGGE_ASSERT_NEXT(a_read_latency, cmd_fire && (cmd.kind == KIND_READ),
                      (state_reg == ST_READ) ##1 out_vld_reg,
                      "read response not posted on time")

endmodule
